// ===== sv/ddrk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrk_pkg
// Shared types, constants and helpers for the differential-drive RK4 step.
// ----------------------------------------------------------------------------
package ddrk_pkg;

  // CORDIC length
  localparam int CordicIterDefault = 16;
  localparam int CordicIterMax     = 30;

  // Step register
  localparam int             DtW         = 17;
  localparam logic [DtW-1:0] DtReset     = 17'd6554;
  localparam logic           RegTimeStep = 1'b0;

  // Datapath widths
  localparam int XyW  = 33;  // CORDIC x/y, Q2.30 with headroom
  localparam int ZW   = 32;  // CORDIC angle, Q2.30
  localparam int SumW = 37;  // RK4 weighted sums

  // Fixed-point constants
  localparam logic signed [23:0] InvTrackQ24   = 24'sd6502797;
  localparam logic signed [31:0] InvTwoPiQ32   = 32'sd683565276;
  localparam logic signed [31:0] HalfPiQ30     = 32'sd1686629713;
  localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
  } ddrk_req_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_heading;
  } ddrk_res_t;

  // Front-end result: speeds and the three stage headings
  typedef struct packed {
    logic               vld;
    logic signed [31:0] v;
    logic signed [32:0] w;
    logic signed [31:0] heading;
    logic signed [31:0] head_half;
    logic signed [31:0] head_full;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } ddrk_front_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] a);
    logic signed [31:0] r;
    if (a > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (a < 48'shFFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  // atan(2^-i) in Q2.30
  function automatic logic signed [31:0] atan_q30(input int idx);
    logic signed [31:0] r;
    case (idx)
      0:  r = 32'sd843314857;
      1:  r = 32'sd497837829;
      2:  r = 32'sd263043837;
      3:  r = 32'sd133525159;
      4:  r = 32'sd67021687;
      5:  r = 32'sd33543516;
      6:  r = 32'sd16775851;
      7:  r = 32'sd8388437;
      8:  r = 32'sd4194283;
      9:  r = 32'sd2097149;
      10: r = 32'sd1048576;
      11: r = 32'sd524288;
      12: r = 32'sd262144;
      13: r = 32'sd131072;
      14: r = 32'sd65536;
      15: r = 32'sd32768;
      16: r = 32'sd16384;
      17: r = 32'sd8192;
      18: r = 32'sd4096;
      19: r = 32'sd2048;
      20: r = 32'sd1024;
      21: r = 32'sd512;
      22: r = 32'sd256;
      23: r = 32'sd128;
      24: r = 32'sd64;
      25: r = 32'sd32;
      26: r = 32'sd16;
      27: r = 32'sd8;
      28: r = 32'sd4;
      29: r = 32'sd2;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ddrk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrk_front
// Four-stage front end: forward speed, turn rate and the RK4 stage headings.
// ----------------------------------------------------------------------------
module ddrk_front
  import ddrk_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  ddrk_req_t      req_i,
  input  logic [DtW-1:0] dt_i,
  output ddrk_front_t    front_o
);

  logic               vld1_q, vld2_q, vld3_q, vld4_q;
  logic signed [32:0] sum_lr_d, diff_d;
  logic signed [31:0] v1_q, v2_q, v3_q, v4_q;
  logic signed [56:0] prodw_d, prodw1_q, wsum_d;
  logic signed [32:0] w2_q, w3_q, w4_q;
  logic signed [50:0] dtw_d, dtw3_q, half_sum_d, full_sum_d;
  logic signed [31:0] th1_q, th2_q, th3_q, th4_q, hh4_q, hf4_q;
  logic signed [31:0] px1_q, px2_q, px3_q, px4_q, py1_q, py2_q, py3_q, py4_q;
  logic signed [33:0] half_d;
  logic signed [34:0] full_d;

  // Mean and difference of the wheel speeds
  assign sum_lr_d = 33'(req_i.left_speed) + 33'(req_i.right_speed);
  assign diff_d   = 33'(req_i.right_speed) - 33'(req_i.left_speed);
  assign prodw_d  = 57'(diff_d) * 57'(InvTrackQ24);

  // Round the turn rate, then scale by the step
  assign wsum_d = prodw1_q + 57'sd8388608;
  assign dtw_d  = 51'($signed({1'b0, dt_i})) * 51'(w2_q);

  // Half and full step heading offsets, rounded
  assign half_sum_d = dtw3_q + 51'sd65536;
  assign full_sum_d = dtw3_q + 51'sd32768;
  assign half_d     = half_sum_d[50:17];
  assign full_d     = full_sum_d[50:16];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    v1_q     <= sum_lr_d[32:1];
    prodw1_q <= prodw_d;
    th1_q    <= req_i.heading;
    px1_q    <= req_i.pos_x;
    py1_q    <= req_i.pos_y;

    v2_q  <= v1_q;
    w2_q  <= wsum_d[56:24];
    th2_q <= th1_q;
    px2_q <= px1_q;
    py2_q <= py1_q;

    v3_q   <= v2_q;
    w3_q   <= w2_q;
    dtw3_q <= dtw_d;
    th3_q  <= th2_q;
    px3_q  <= px2_q;
    py3_q  <= py2_q;

    v4_q  <= v3_q;
    w4_q  <= w3_q;
    th4_q <= th3_q;
    hh4_q <= sat32(48'(th3_q) + 48'(half_d));
    hf4_q <= sat32(48'(th3_q) + 48'(full_d));
    px4_q <= px3_q;
    py4_q <= py3_q;
  end

  assign front_o = '{vld: vld4_q, v: v4_q, w: w4_q, heading: th4_q,
                     head_half: hh4_q, head_full: hf4_q,
                     pos_x: px4_q, pos_y: py4_q};

endmodule

// ===== sv/ddrk_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrk_cordic
// Pipelined sine and cosine: angle reduction to a quadrant, one rotation per
// stage, then quadrant fix-up.
// ----------------------------------------------------------------------------
module ddrk_cordic
  import ddrk_pkg::*;
#(
  parameter int Iters = CordicIterDefault
) (
  input  logic                  clk_i,
  input  logic signed [31:0]    angle_i,
  output logic signed [XyW-1:0] cos_o,
  output logic signed [XyW-1:0] sin_o
);

  logic signed [62:0]    turns_d;
  logic [31:0]           phase_q, pp_d;
  logic signed [29:0]    resid_d;
  logic signed [61:0]    zprod_d, zprod_q, zrnd_d;
  logic [1:0]            quadb_q;
  logic signed [XyW-1:0] x_q [Iters+1];
  logic signed [XyW-1:0] y_q [Iters+1];
  logic signed [ZW-1:0]  z_q [Iters+1];
  logic [1:0]            quad_q [Iters+1];
  logic signed [XyW-1:0] cos_q, sin_q;

  // Turns of the angle, low 48 bits give the phase
  assign turns_d = 63'(angle_i) * 63'(InvTwoPiQ32);

  // Split into nearest quadrant and residual, residual to radians
  assign pp_d    = phase_q + 32'h2000_0000;
  assign resid_d = {~pp_d[29], pp_d[28:0]};
  assign zprod_d = 62'(resid_d) * 62'(HalfPiQ30);
  assign zrnd_d  = zprod_q + 62'sd536870912;

  always_ff @(posedge clk_i) begin
    phase_q   <= turns_d[47:16];
    zprod_q   <= zprod_d;
    quadb_q   <= pp_d[31:30];
    x_q[0]    <= XyW'(CordicGainQ30);
    y_q[0]    <= '0;
    z_q[0]    <= zrnd_d[30+ZW-1:30];
    quad_q[0] <= quadb_q;
  end

  // One rotation per stage
  for (genvar i = 0; i < Iters; i++) begin : g_iter
    logic signed [XyW-1:0] dx, dy, x_d, y_d;
    logic signed [ZW-1:0]  z_d;

    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;

    always_comb begin
      if (!z_q[i][ZW-1]) begin
        x_d = x_q[i] - dy;
        y_d = y_q[i] + dx;
        z_d = z_q[i] - ZW'(atan_q30(i));
      end else begin
        x_d = x_q[i] + dy;
        y_d = y_q[i] - dx;
        z_d = z_q[i] + ZW'(atan_q30(i));
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_d;
      y_q[i+1]    <= y_d;
      z_q[i+1]    <= z_d;
      quad_q[i+1] <= quad_q[i];
    end
  end

  // Rotate by the quadrant
  always_ff @(posedge clk_i) begin
    case (quad_q[Iters])
      2'd0: begin
        cos_q <= x_q[Iters];
        sin_q <= y_q[Iters];
      end
      2'd1: begin
        cos_q <= -y_q[Iters];
        sin_q <= x_q[Iters];
      end
      2'd2: begin
        cos_q <= -x_q[Iters];
        sin_q <= -y_q[Iters];
      end
      default: begin
        cos_q <= y_q[Iters];
        sin_q <= -x_q[Iters];
      end
    endcase
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== sv/ddrk_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrk_update
// Four-stage pose update: base + round(dt * sum / (6 * 2^16)), saturated.
// The divide by three splits the value into an 18-bit low part and a high
// part, using 2^18 = 3 * 87381 + 1, and finishes with a reciprocal multiply.
// ----------------------------------------------------------------------------
module ddrk_update
  import ddrk_pkg::*;
(
  input  logic                   clk_i,
  input  logic signed [SumW-1:0] sum_i,
  input  logic [DtW-1:0]         dt_i,
  input  logic signed [31:0]     base_i,
  output logic signed [31:0]     res_o
);

  logic signed [54:0] prod_d, prod_q, msum_d;
  logic signed [38:0] off_d;
  logic [19:0]        uh_d, uh_q, qb_q;
  logic [17:0]        ul_d;
  logic [20:0]        t_q;
  logic [36:0]        qa_d, qa_q;
  logic [41:0]        qb_d;
  logic signed [38:0] q_d;
  logic signed [31:0] b1_q, b2_q, b3_q, res_q;

  // Scale the sum by the step
  assign prod_d = 55'($signed({1'b0, dt_i})) * 55'(sum_i);

  // Add the rounding term, divide by 2^17 and shift positive by 3 * 2^36
  assign msum_d = prod_q + 55'sd196608;
  assign off_d  = 39'(msum_d[54:17]) + 39'sd206158430208;
  assign uh_d   = off_d[37:18];
  assign ul_d   = off_d[17:0];

  // Quotient pieces
  assign qa_d = 37'(uh_q) * 37'(17'd87381);
  assign qb_d = 42'(t_q) * 42'(21'd1398102);

  // Reassemble and remove the offset
  assign q_d = $signed({2'b00, qa_q}) + $signed(39'(qb_q)) - 39'sd68719476736;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    b1_q   <= base_i;
    uh_q   <= uh_d;
    t_q    <= 21'(uh_d) + 21'(ul_d);
    b2_q   <= b1_q;
    qa_q   <= qa_d;
    qb_q   <= qb_d[41:22];
    b3_q   <= b2_q;
    res_q  <= sat32(48'(b3_q) + 48'(q_d));
  end

  assign res_o = res_q;

endmodule

// ===== sv/diff_drive_rk4_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_rk4_step
// One fourth-order Runge-Kutta step of differential-drive kinematics.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a pose and wheel speeds on req_i; the request is taken
//   at that edge whenever busy is low, and busy stays low, so a new request
//   may enter every cycle.
//   Each request gives one result on result_o, marked by done_o for exactly
//   one cycle, in request order. The receiver cannot stall the block.
//   CORDIC_ITERATIONS defaults to 16 and is capped at 30. The pipeline has
//   4 front-end stages, the CORDIC pipeline (one stage per rotation plus 4),
//   3 derivative stages and 4 update stages. Throughput is one per cycle.
//   time_step sits at APB address 0; the user must write it only while no
//   request is in flight, as the block itself does not enforce this.
//   Reset clears all valid bits, so no stray done_o appears, and loads
//   time_step with 6554 (about 0.1 s).
// ----------------------------------------------------------------------------
module diff_drive_rk4_step
  import ddrk_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CordicIterDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ddrk_req_t   req_i,
  output logic        done_o,
  output ddrk_res_t   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int Iters   = (CORDIC_ITERATIONS > CordicIterMax) ? CordicIterMax
                                                                 : CORDIC_ITERATIONS;
  localparam int CordLat = Iters + 4;
  localparam int UpdLat  = 4;

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [32:0] w;
    logic signed [31:0] heading;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } side_t;

  logic [DtW-1:0]        dt_q;
  ddrk_front_t           front;
  logic signed [XyW-1:0] cosv [3];
  logic signed [XyW-1:0] sinv [3];
  logic signed [31:0]    angles [3];
  side_t                 side_q [CordLat];
  logic [CordLat-1:0]    cvld_q;
  logic [2:0]            kvld_q;
  side_t                 k1_q, k2_q;
  logic signed [64:0]    pc_q [3];
  logic signed [64:0]    ps_q [3];
  logic signed [32:0]    kc_q [3];
  logic signed [32:0]    ks_q [3];
  logic signed [SumW-1:0] sx_q, sy_q, st_q;
  logic signed [31:0]    bx_q, by_q, bt_q;
  logic [UpdLat-1:0]     uvld_q;
  logic signed [31:0]    nx, ny, nt;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTimeStep) ? {{(32-DtW){1'b0}}, dt_q} : 32'd0;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= DtReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegTimeStep)) begin
      dt_q <= pwdata[DtW-1:0];
    end
  end

  // Speeds and stage headings
  ddrk_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .req_i   (req_i),
    .dt_i    (dt_q),
    .front_o (front)
  );

  // Sine and cosine at start, midpoint and end headings
  assign angles[0] = front.heading;
  assign angles[1] = front.head_half;
  assign angles[2] = front.head_full;

  for (genvar j = 0; j < 3; j++) begin : g_cordic
    ddrk_cordic #(.Iters(Iters)) u_cordic (
      .clk_i   (clk_i),
      .angle_i (angles[j]),
      .cos_o   (cosv[j]),
      .sin_o   (sinv[j])
    );
  end

  // Hold speeds and pose alongside the CORDIC pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= '0;
      kvld_q <= '0;
      uvld_q <= '0;
    end else begin
      cvld_q <= {cvld_q[CordLat-2:0], front.vld};
      kvld_q <= {kvld_q[1:0], cvld_q[CordLat-1]};
      uvld_q <= {uvld_q[UpdLat-2:0], kvld_q[2]};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{v: front.v, w: front.w, heading: front.heading,
                   pos_x: front.pos_x, pos_y: front.pos_y};
  end

  for (genvar d = 1; d < CordLat; d++) begin : g_delay
    always_ff @(posedge clk_i) begin
      side_q[d] <= side_q[d-1];
    end
  end

  // Derivatives: multiply, round, then weighted sum k1 + 4 k2 + k4
  for (genvar j = 0; j < 3; j++) begin : g_deriv
    logic signed [64:0] rc, rs;
    assign rc = pc_q[j] + 65'sd536870912;
    assign rs = ps_q[j] + 65'sd536870912;
    always_ff @(posedge clk_i) begin
      pc_q[j] <= 65'(side_q[CordLat-1].v) * 65'(cosv[j]);
      ps_q[j] <= 65'(side_q[CordLat-1].v) * 65'(sinv[j]);
      kc_q[j] <= rc[62:30];
      ks_q[j] <= rs[62:30];
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q <= side_q[CordLat-1];
    k2_q <= k1_q;
    sx_q <= SumW'(kc_q[0]) + (SumW'(kc_q[1]) <<< 2) + SumW'(kc_q[2]);
    sy_q <= SumW'(ks_q[0]) + (SumW'(ks_q[1]) <<< 2) + SumW'(ks_q[2]);
    st_q <= (SumW'(k2_q.w) <<< 2) + (SumW'(k2_q.w) <<< 1);
    bx_q <= k2_q.pos_x;
    by_q <= k2_q.pos_y;
    bt_q <= k2_q.heading;
  end

  // Pose update lanes
  ddrk_update u_upd_x (
    .clk_i (clk_i), .sum_i (sx_q), .dt_i (dt_q), .base_i (bx_q), .res_o (nx)
  );
  ddrk_update u_upd_y (
    .clk_i (clk_i), .sum_i (sy_q), .dt_i (dt_q), .base_i (by_q), .res_o (ny)
  );
  ddrk_update u_upd_t (
    .clk_i (clk_i), .sum_i (st_q), .dt_i (dt_q), .base_i (bt_q), .res_o (nt)
  );

  assign done_o                = uvld_q[UpdLat-1];
  assign result_o.next_x       = nx;
  assign result_o.next_y       = ny;
  assign result_o.next_heading = nt;

endmodule
